// ===== hdl/vrp_pkg.sv =====
`default_nettype none

package vrp_pkg;

   // Block geometry and number format.
   localparam int FRAC_BITS     = 16;
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 128;

   // Field and register widths.
   localparam int VTX_W  = 32;
   localparam int ROT_W  = 18;
   localparam int PROJ_W = 24;
   localparam int SCR_W  = 16;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 5;

   // Datapath widths for the front end. With 16 fraction bits the rotated
   // coordinates stay well inside the +-2^37 limit of Y2_W, so no clamp is built.
   localparam int P1_W  = VTX_W + ROT_W;   // x*cos and friends
   localparam int S2_W  = P1_W + 1;        // sum of two products
   localparam int X1_W  = S2_W - FRAC_BITS;
   localparam int P3_W  = X1_W + ROT_W;
   localparam int S4_W  = P3_W + 1;
   localparam int Y2_W  = S4_W - FRAC_BITS;
   localparam int W_W   = Y2_W + 1;        // translated depth
   localparam int NP_W  = Y2_W + PROJ_W;   // projected numerator
   localparam int ADJ_W = NP_W + 1;

   // Divider widths: magnitude of the numerator, of the divisor and the
   // quotient bits kept below the saturation level 2^44.
   localparam int NUM_W = NP_W;
   localparam int DEN_W = W_W;
   localparam int QUO_W = 45;

   // Screen mapping widths.
   localparam int SIZE_W = 14;
   localparam int M1_W   = QUO_W + 2;
   localparam int M2_W   = M1_W + SIZE_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      ADDR_COS_Z        = 3'd0,
      ADDR_SIN_Z        = 3'd1,
      ADDR_COS_X        = 3'd2,
      ADDR_SIN_X        = 3'd3,
      ADDR_PROJ_X_SCALE = 3'd4,
      ADDR_PROJ_Y_SCALE = 3'd5,
      ADDR_DEPTH_SCALE  = 3'd6,
      ADDR_DEPTH_OFFSET = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic signed [ROT_W-1:0]  cos_z;
      logic signed [ROT_W-1:0]  sin_z;
      logic signed [ROT_W-1:0]  cos_x;
      logic signed [ROT_W-1:0]  sin_x;
      logic signed [PROJ_W-1:0] proj_x_scale;
      logic signed [PROJ_W-1:0] proj_y_scale;
      logic signed [PROJ_W-1:0] depth_scale;
      logic signed [PROJ_W-1:0] depth_offset;
   } cfg_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [NUM_W-1:0] num;
   } div_arg_type;

   typedef struct packed {
      div_arg_type      px;
      div_arg_type      py;
      logic [DEN_W-1:0] den;
      logic             skip;
   } job_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] qn;
   } lane_type;

   typedef struct packed {
      logic neg_x;
      logic ovf_x;
      logic neg_y;
      logic ovf_y;
      logic skip;
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/vrp_front.sv =====
`default_nettype none

module vrp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  vrp_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_x,
   input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_y,
   input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_z,
   input  logic                                job_full,
   output logic                                job_valid,
   output vrp_pkg::job_type                    job
);
   import vrp_pkg::*;

   localparam int STAGES = 7;
   localparam logic signed [W_W-1:0]   DEPTH_BIAS = W_W'(64'd8 << FRAC_BITS);
   localparam logic signed [W_W-1:0]   DEN_ONE    = W_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ADJ_W-1:0] SKIP_ROUND = ADJ_W'((64'd1 << FRAC_BITS) - 64'd1);

   logic en;
   logic [STAGES-1:0] valid_ff, valid_in;

   // Stage 1: Z rotation products.
   logic signed [P1_W-1:0] xcz_ff, ysz_ff, xsz_ff, ycz_ff, xcz_in, ysz_in, xsz_in, ycz_in;
   logic signed [VTX_W-1:0] z1_ff;
   // Stage 2: Z rotation sums.
   logic signed [S2_W-1:0] sa2, sb2;
   logic signed [X1_W-1:0] x1_ff, y1_ff, x1_in, y1_in;
   logic signed [VTX_W-1:0] z2_ff;
   // Stage 3: X rotation products.
   logic signed [P3_W-1:0] ycx_ff, zsx_ff, ysx_ff, zcx_ff, ycx_in, zsx_in, ysx_in, zcx_in;
   logic signed [X1_W-1:0] x3_ff;
   // Stage 4: X rotation sums.
   logic signed [S4_W-1:0] sa4, sb4;
   logic signed [Y2_W-1:0] y4_ff, z4_ff, y4_in, z4_in;
   logic signed [X1_W-1:0] x4_ff;
   // Stage 5: projection products and translated depth.
   logic signed [NP_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [W_W-1:0]  w_ff, w_in;
   // Stage 6: zero-depth handling.
   logic                    skip_ff, skip_in;
   logic signed [ADJ_W-1:0] nxa_ff, nya_ff, nxa_in, nya_in;
   logic signed [W_W-1:0]   den_ff, den_in;
   // Stage 7: magnitudes for the divider.
   logic [ADJ_W-1:0] ax, ay;
   logic [W_W-1:0]   ad;
   job_type          job_ff, job_in;

   assign en       = !job_full;
   assign in_ready = en;
   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      xcz_in = vertex_x * cfg.cos_z;
      ysz_in = vertex_y * cfg.sin_z;
      xsz_in = vertex_x * cfg.sin_z;
      ycz_in = vertex_y * cfg.cos_z;

      sa2   = S2_W'(xcz_ff) - S2_W'(ysz_ff);
      sb2   = S2_W'(xsz_ff) + S2_W'(ycz_ff);
      x1_in = X1_W'(sa2 >>> FRAC_BITS);
      y1_in = X1_W'(sb2 >>> FRAC_BITS);

      ycx_in = y1_ff * cfg.cos_x;
      zsx_in = z2_ff * cfg.sin_x;
      ysx_in = y1_ff * cfg.sin_x;
      zcx_in = z2_ff * cfg.cos_x;

      sa4   = S4_W'(ycx_ff) - S4_W'(zsx_ff);
      sb4   = S4_W'(ysx_ff) + S4_W'(zcx_ff);
      y4_in = Y2_W'(sa4 >>> FRAC_BITS);
      z4_in = Y2_W'(sb4 >>> FRAC_BITS);

      nx_in = x4_ff * cfg.proj_x_scale;
      ny_in = y4_ff * cfg.proj_y_scale;
      w_in  = W_W'(z4_ff) + DEPTH_BIAS;

      // At zero depth the quotient by 1.0 must round toward minus infinity,
      // so a negative numerator is pulled down before the truncating divide.
      skip_in = (w_ff == '0);
      den_in  = skip_in ? DEN_ONE : w_ff;
      nxa_in  = (skip_in && nx_ff < 0) ? ADJ_W'(nx_ff) - SKIP_ROUND : ADJ_W'(nx_ff);
      nya_in  = (skip_in && ny_ff < 0) ? ADJ_W'(ny_ff) - SKIP_ROUND : ADJ_W'(ny_ff);

      ax = nxa_ff[ADJ_W-1] ? ADJ_W'(-nxa_ff) : ADJ_W'(nxa_ff);
      ay = nya_ff[ADJ_W-1] ? ADJ_W'(-nya_ff) : ADJ_W'(nya_ff);
      ad = den_ff[W_W-1] ? W_W'(-den_ff) : W_W'(den_ff);
      job_in.px.neg = nxa_ff[ADJ_W-1] ^ den_ff[W_W-1];
      job_in.px.num = ax[NUM_W-1:0];
      job_in.px.ovf = DEN_W'(ax[NUM_W-1:QUO_W]) >= ad;
      job_in.py.neg = nya_ff[ADJ_W-1] ^ den_ff[W_W-1];
      job_in.py.num = ay[NUM_W-1:0];
      job_in.py.ovf = DEN_W'(ay[NUM_W-1:QUO_W]) >= ad;
      job_in.den    = ad;
      job_in.skip   = skip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xcz_ff  <= xcz_in;
         ysz_ff  <= ysz_in;
         xsz_ff  <= xsz_in;
         ycz_ff  <= ycz_in;
         z1_ff   <= vertex_z;
         x1_ff   <= x1_in;
         y1_ff   <= y1_in;
         z2_ff   <= z1_ff;
         ycx_ff  <= ycx_in;
         zsx_ff  <= zsx_in;
         ysx_ff  <= ysx_in;
         zcx_ff  <= zcx_in;
         x3_ff   <= x1_ff;
         y4_ff   <= y4_in;
         z4_ff   <= z4_in;
         x4_ff   <= x3_ff;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         w_ff    <= w_in;
         skip_ff <= skip_in;
         nxa_ff  <= nxa_in;
         nya_ff  <= nya_in;
         den_ff  <= den_in;
         job_ff  <= job_in;
      end
   end

   assign job_valid = valid_ff[STAGES-1] && en;
   assign job       = job_ff;

endmodule

`default_nettype wire

// ===== hdl/vrp_queue.sv =====
`default_nettype none

module vrp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vrp_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output vrp_pkg::job_type head_job
);
   import vrp_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vrp_back.sv =====
`default_nettype none

module vrp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  vrp_pkg::job_type                  job,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [vrp_pkg::SCR_W-1:0]  screen_x,
   output logic signed [vrp_pkg::SCR_W-1:0]  screen_y,
   output logic                              divide_skipped,
   output logic                              clipped
);
   import vrp_pkg::*;

   localparam logic [QUO_W-1:0]        PROJ_LIMIT = QUO_W'(1) << (QUO_W - 1);
   localparam logic signed [M1_W-1:0]  M1_ONE     = M1_W'(64'd1 << FRAC_BITS);
   localparam logic signed [SIZE_W-1:0] SIZE_X    = SIZE_W'(SCREEN_WIDTH);
   localparam logic signed [SIZE_W-1:0] SIZE_Y    = SIZE_W'(SCREEN_HEIGHT);
   localparam logic signed [M2_W-1:0]  RND        = M2_W'((64'd1 << (FRAC_BITS + 1)) - 64'd1);
   localparam logic signed [M2_W-1:0]  SAT_HI     = M2_W'(32767);
   localparam logic signed [M2_W-1:0]  SAT_LO     = -M2_W'(32768);

   // One restoring step: bring down the next numerator bit, subtract if it fits.
   function automatic lane_type div_step(input lane_type src, input logic [DEN_W-1:0] den);
      logic [DEN_W:0] rs;
      lane_type       res;
      rs = {src.rem, src.qn[QUO_W-1]};
      if (rs >= {1'b0, den}) begin
         res.rem = DEN_W'(rs - {1'b0, den});
         res.qn  = {src.qn[QUO_W-2:0], 1'b1};
      end else begin
         res.rem = DEN_W'(rs);
         res.qn  = {src.qn[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

   // Projected value with clamp, sign and the +1.0 screen offset applied.
   function automatic logic signed [M1_W-1:0] offset_proj(input logic [QUO_W-1:0] q,
                                                          input logic ovf, input logic neg);
      logic [QUO_W-1:0]       mag;
      logic signed [M1_W-1:0] pv;
      mag = (ovf || q > PROJ_LIMIT) ? PROJ_LIMIT : q;
      pv  = {2'b00, mag};
      if (neg) begin
         pv = -pv;
      end
      return pv + M1_ONE;
   endfunction

   logic en;

   lane_type         lx_ff [QUO_W];
   lane_type         ly_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   side_type         side_ff [QUO_W];
   logic [QUO_W-1:0] dvalid_ff;

   lane_type         src_x [QUO_W];
   lane_type         src_y [QUO_W];
   logic [DEN_W-1:0] src_den [QUO_W];
   side_type         src_side [QUO_W];

   logic                   m1_valid_ff, m2_valid_ff, out_valid_ff;
   logic signed [M1_W-1:0] m1x_ff, m1y_ff, m1x_in, m1y_in;
   logic signed [M2_W-1:0] m2x_ff, m2y_ff, m2x_in, m2y_in;
   logic                   m1_skip_ff, m2_skip_ff;
   logic signed [M2_W-1:0] rx, ry, sx, sy;
   logic                   clip_x, clip_y;
   logic signed [SCR_W-1:0] scr_x_ff, scr_y_ff, scr_x_in, scr_y_in;
   logic                   skip_out_ff, clip_out_ff;

   assign en  = !out_valid_ff || out_ready;
   assign pop = en && job_valid;

   always_comb begin
      src_x[0].rem       = DEN_W'(job.px.num[NUM_W-1:QUO_W]);
      src_x[0].qn        = job.px.num[QUO_W-1:0];
      src_y[0].rem       = DEN_W'(job.py.num[NUM_W-1:QUO_W]);
      src_y[0].qn        = job.py.num[QUO_W-1:0];
      src_den[0]         = job.den;
      src_side[0].neg_x  = job.px.neg;
      src_side[0].ovf_x  = job.px.ovf;
      src_side[0].neg_y  = job.py.neg;
      src_side[0].ovf_y  = job.py.ovf;
      src_side[0].skip   = job.skip;
      for (int k = 1; k < QUO_W; k++) begin
         src_x[k]    = lx_ff[k-1];
         src_y[k]    = ly_ff[k-1];
         src_den[k]  = den_ff[k-1];
         src_side[k] = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QUO_W; k++) begin
            lx_ff[k]   <= div_step(src_x[k], src_den[k]);
            ly_ff[k]   <= div_step(src_y[k], src_den[k]);
            den_ff[k]  <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   always_comb begin
      m1x_in = offset_proj(lx_ff[QUO_W-1].qn, side_ff[QUO_W-1].ovf_x, side_ff[QUO_W-1].neg_x);
      m1y_in = offset_proj(ly_ff[QUO_W-1].qn, side_ff[QUO_W-1].ovf_y, side_ff[QUO_W-1].neg_y);
      m2x_in = m1x_ff * SIZE_X;
      m2y_in = m1y_ff * SIZE_Y;

      // Divide by 2^(F+1) with truncation toward zero, then saturate.
      rx     = (m2x_ff < 0) ? m2x_ff + RND : m2x_ff;
      ry     = (m2y_ff < 0) ? m2y_ff + RND : m2y_ff;
      sx     = rx >>> (FRAC_BITS + 1);
      sy     = ry >>> (FRAC_BITS + 1);
      clip_x = (sx > SAT_HI) || (sx < SAT_LO);
      clip_y = (sy > SAT_HI) || (sy < SAT_LO);
      if (sx > SAT_HI) begin
         scr_x_in = SCR_W'(SAT_HI);
      end else if (sx < SAT_LO) begin
         scr_x_in = SCR_W'(SAT_LO);
      end else begin
         scr_x_in = SCR_W'(sx);
      end
      if (sy > SAT_HI) begin
         scr_y_in = SCR_W'(SAT_HI);
      end else if (sy < SAT_LO) begin
         scr_y_in = SCR_W'(SAT_LO);
      end else begin
         scr_y_in = SCR_W'(sy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff    <= '0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         dvalid_ff    <= {dvalid_ff[QUO_W-2:0], job_valid};
         m1_valid_ff  <= dvalid_ff[QUO_W-1];
         m2_valid_ff  <= m1_valid_ff;
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1x_ff      <= m1x_in;
         m1y_ff      <= m1y_in;
         m1_skip_ff  <= side_ff[QUO_W-1].skip;
         m2x_ff      <= m2x_in;
         m2y_ff      <= m2y_in;
         m2_skip_ff  <= m1_skip_ff;
         scr_x_ff    <= scr_x_in;
         scr_y_ff    <= scr_y_in;
         skip_out_ff <= m2_skip_ff;
         clip_out_ff <= clip_x || clip_y;
      end
   end

   assign out_valid      = out_valid_ff;
   assign screen_x       = scr_x_ff;
   assign screen_y       = scr_y_ff;
   assign divide_skipped = skip_out_ff;
   assign clipped        = clip_out_ff;

endmodule

`default_nettype wire

// ===== hdl/vertex_rotate_project_unit.sv =====
`default_nettype none

// Channel   Direction  Beat contents
// req_      in         tdata: vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
// rsp_      out        tdata: screen_x [15:0], screen_y [31:16];
//                      tuser: divide_skipped [0], clipped [1]
// csr_      in         APB writes and reads of the eight transform registers
//
// One vertex per cycle is accepted while the queue is not full, and one
// result per cycle is delivered while rsp_tready is high. The path holds
// 7 front stages (rotation, projection, divide setup), the queue, a 45-stage
// restoring divider (one quotient bit per stage) and 3 screen mapping stages.
// Synchronous reset empties all stages. A stalled result holds the back end;
// the front keeps accepting until the four-entry queue is full.

module vertex_rotate_project_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [95:0]                 req_tdata,  // vertex_x, vertex_y, vertex_z
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,  // screen_x, screen_y
   output logic [1:0]                  rsp_tuser,  // divide_skipped, clipped
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [vrp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [vrp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [vrp_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import vrp_pkg::*;

   cfg_type      cfg_ff;
   csr_addr_type addr;
   logic         wr_en;

   logic    job_valid, job_full, pop, head_valid;
   job_type job, head_job;
   logic signed [SCR_W-1:0] screen_x, screen_y;
   logic    divide_skipped, clipped;

   assign csr_pready = 1'b1;
   assign addr       = csr_addr_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_z        <= ROT_W'(65536);
         cfg_ff.sin_z        <= '0;
         cfg_ff.cos_x        <= ROT_W'(65536);
         cfg_ff.sin_x        <= '0;
         cfg_ff.proj_x_scale <= PROJ_W'(65536);
         cfg_ff.proj_y_scale <= PROJ_W'(65536);
         cfg_ff.depth_scale  <= PROJ_W'(65543);
         cfg_ff.depth_offset <= -PROJ_W'(6554);
      end else if (wr_en) begin
         case (addr)
            ADDR_COS_Z:        cfg_ff.cos_z        <= csr_pwdata[ROT_W-1:0];
            ADDR_SIN_Z:        cfg_ff.sin_z        <= csr_pwdata[ROT_W-1:0];
            ADDR_COS_X:        cfg_ff.cos_x        <= csr_pwdata[ROT_W-1:0];
            ADDR_SIN_X:        cfg_ff.sin_x        <= csr_pwdata[ROT_W-1:0];
            ADDR_PROJ_X_SCALE: cfg_ff.proj_x_scale <= csr_pwdata[PROJ_W-1:0];
            ADDR_PROJ_Y_SCALE: cfg_ff.proj_y_scale <= csr_pwdata[PROJ_W-1:0];
            ADDR_DEPTH_SCALE:  cfg_ff.depth_scale  <= csr_pwdata[PROJ_W-1:0];
            ADDR_DEPTH_OFFSET: cfg_ff.depth_offset <= csr_pwdata[PROJ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (addr)
         ADDR_COS_Z:        csr_prdata = CSR_DW'(cfg_ff.cos_z);
         ADDR_SIN_Z:        csr_prdata = CSR_DW'(cfg_ff.sin_z);
         ADDR_COS_X:        csr_prdata = CSR_DW'(cfg_ff.cos_x);
         ADDR_SIN_X:        csr_prdata = CSR_DW'(cfg_ff.sin_x);
         ADDR_PROJ_X_SCALE: csr_prdata = CSR_DW'(cfg_ff.proj_x_scale);
         ADDR_PROJ_Y_SCALE: csr_prdata = CSR_DW'(cfg_ff.proj_y_scale);
         ADDR_DEPTH_SCALE:  csr_prdata = CSR_DW'(cfg_ff.depth_scale);
         ADDR_DEPTH_OFFSET: csr_prdata = CSR_DW'(cfg_ff.depth_offset);
         default:           csr_prdata = '0;
      endcase
   end

   vrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vertex_x  (req_tdata[31:0]),
      .vertex_y  (req_tdata[63:32]),
      .vertex_z  (req_tdata[95:64]),
      .job_full  (job_full),
      .job_valid (job_valid),
      .job       (job)
   );

   vrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .full       (job_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   vrp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .screen_x       (screen_x),
      .screen_y       (screen_y),
      .divide_skipped (divide_skipped),
      .clipped        (clipped)
   );

   assign rsp_tdata = {screen_y, screen_x};
   assign rsp_tuser = {clipped, divide_skipped};

endmodule

`default_nettype wire
